[sv/tcpck_pkg.sv]
// Shared types and ones' complement helpers for the TCP/Internet checksum block.
`timescale 1ns / 1ps
`default_nettype none

package tcpck_pkg;

    // Protocol number added into the TCP pseudo-header
    localparam logic [15:0] PROTO_TCP = 16'd6;

    // Sum kinds
    localparam logic KIND_PLAIN = 1'b0;
    localparam logic KIND_TCP   = 1'b1;

    // One message byte with its side information and precomputed start sum
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic        sum_kind;
        logic [15:0] start_sum;
    } tcpck_item_t;

    // Fold a sum of up to eight 16-bit words to 16 bits with end-around carry
    function automatic logic [15:0] fold16(input logic [18:0] s);
        logic [16:0] t;
        logic [16:0] r;
        t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
        r = {1'b0, t[15:0]} + {16'd0, t[16]};
        return r[15:0];
    endfunction

endpackage

`default_nettype wire

[sv/tcpck_in_stage.sv]
// Input register: captures a request and its precomputed message start sum.
`timescale 1ns / 1ps
`default_nettype none

module tcpck_in_stage
    import tcpck_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [87:0] s_axis_tdata,  // data_byte, init_sum, src_addr, dst_addr
    input  wire logic        s_axis_tlast,  // last_byte
    input  wire logic [1:0]  s_axis_tuser,  // first_byte, sum_kind
    output logic             item_valid,
    input  wire logic        item_ready,
    output tcpck_item_t      item
);

    logic        valid_reg;
    tcpck_item_t item_reg;
    tcpck_item_t item_next;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [18:0] pseudo_total;
    logic [15:0] pseudo_sum;
    logic        take;

    assign src_addr = s_axis_tdata[55:24];
    assign dst_addr = s_axis_tdata[87:56];

    // Sum the pseudo-header words: addresses and protocol
    always_comb
    begin
        pseudo_total = {3'd0, src_addr[31:16]} + {3'd0, src_addr[15:0]}
                     + {3'd0, dst_addr[31:16]} + {3'd0, dst_addr[15:0]}
                     + {3'd0, PROTO_TCP};
        pseudo_sum   = fold16(pseudo_total);
    end

    // Pick the start value for the kind of message
    always_comb
    begin
        item_next.data_byte  = s_axis_tdata[7:0];
        item_next.first_byte = s_axis_tuser[0];
        item_next.last_byte  = s_axis_tlast;
        item_next.sum_kind   = s_axis_tuser[1];
        item_next.start_sum  = (s_axis_tuser[1] == KIND_TCP) ? pseudo_sum
                                                              : s_axis_tdata[23:8];
    end

    assign s_axis_tready = !valid_reg || item_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[sv/tcpck_accum.sv]
// Running ones' complement accumulator and result register.
`timescale 1ns / 1ps
`default_nettype none

module tcpck_accum
    import tcpck_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire tcpck_item_t item,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // checksum, byte_count
);

    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [7:0]  held_reg;
    logic [7:0]  held_next;
    logic        odd_reg;
    logic        odd_next;
    logic [15:0] len_reg;
    logic [15:0] len_next;
    logic        kind_reg;
    logic        kind_next;
    logic        out_valid_reg;
    logic [15:0] checksum_reg;
    logic [15:0] checksum_next;
    logic [15:0] count_reg;

    logic        out_free;
    logic        consume;
    logic [15:0] base_sum;
    logic [7:0]  base_held;
    logic        base_odd;
    logic [15:0] base_len;
    logic [15:0] len_inc;
    logic [15:0] pair_word;
    logic [15:0] final_word;
    logic [15:0] len_term;
    logic [18:0] final_total;
    logic [15:0] final_sum;

    assign out_free   = !out_valid_reg || m_axis_tready;
    assign consume    = item_valid && (!item.last_byte || out_free);
    assign item_ready = !item.last_byte || out_free;

    // Start from the message opening state or the running state
    always_comb
    begin
        base_sum  = item.first_byte ? item.start_sum : sum_reg;
        base_held = item.first_byte ? 8'd0 : held_reg;
        base_odd  = item.first_byte ? 1'b0 : odd_reg;
        base_len  = item.first_byte ? 16'd0 : len_reg;
        kind_next = item.first_byte ? item.sum_kind : kind_reg;
        len_inc   = base_len + 16'd1;
        pair_word = {base_held, item.data_byte};
    end

    // Advance the running state by one byte, or clear it on the last byte
    always_comb
    begin
        if (item.last_byte)
        begin
            sum_next  = 16'd0;
            held_next = 8'd0;
            odd_next  = 1'b0;
            len_next  = 16'd0;
        end
        else if (base_odd)
        begin
            sum_next  = fold16({3'd0, base_sum} + {3'd0, pair_word});
            held_next = 8'd0;
            odd_next  = 1'b0;
            len_next  = len_inc;
        end
        else
        begin
            sum_next  = base_sum;
            held_next = item.data_byte;
            odd_next  = 1'b1;
            len_next  = len_inc;
        end
    end

    // Close the message: pending word, odd high byte, length for TCP
    always_comb
    begin
        final_word    = base_odd ? pair_word : {item.data_byte, 8'd0};
        len_term      = (kind_next == KIND_TCP) ? len_inc : 16'd0;
        final_total   = {3'd0, base_sum} + {3'd0, final_word} + {3'd0, len_term};
        final_sum     = fold16(final_total);
        checksum_next = (kind_next == KIND_TCP) ? ~final_sum : final_sum;
    end

    // Hold the message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= 16'd0;
            held_reg <= 8'd0;
            odd_reg  <= 1'b0;
            len_reg  <= 16'd0;
            kind_reg <= KIND_PLAIN;
        end
        else if (consume)
        begin
            sum_reg  <= sum_next;
            held_reg <= held_next;
            odd_reg  <= odd_next;
            len_reg  <= len_next;
            kind_reg <= kind_next;
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (consume && item.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && item.last_byte)
        begin
            checksum_reg <= checksum_next;
            count_reg    <= len_inc;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {count_reg, checksum_reg};

`ifndef SYNTHESIS
    // A closed message leaves a cleared state
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        consume && item.last_byte |=> len_reg == 16'd0 && odd_reg == 1'b0
                                      && sum_reg == 16'd0)
        else $error("message state not cleared after last byte");

    // An opening byte that does not close leaves one byte pending
    a_open_state: assert property (@(posedge clk) disable iff (!rst_n)
        consume && item.first_byte && !item.last_byte |=> len_reg == 16'd1 && odd_reg)
        else $error("opening byte left wrong state");

    // A middle byte advances the count and flips the phase
    a_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
        consume && !item.first_byte && !item.last_byte
        |=> len_reg == $past(len_reg) + 16'd1 && odd_reg != $past(odd_reg))
        else $error("byte count or phase did not advance");

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !(consume && item.last_byte))
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

[sv/tcp_internet_checksum.sv]
// Top level of the byte-stream Internet checksum with optional TCP pseudo-header.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one message byte per clock cycle, sustained while no last byte
// waits on a stalled result, and gives one result per message: the input
// register takes the last byte, and the accumulator then writes the result
// register once it is free. The rate is set by the accumulator loop: one
// 16-bit ones' complement add with end-around carry per byte. The first
// byte of a message (tuser bit 0) latches the sum kind (tuser bit 1) and
// the start value: init_sum for a plain sum, the pseudo-header (addresses
// and protocol 6) for TCP. The plain kind returns the folded sum; the TCP
// kind adds the byte count and returns the complement. A stalled result
// does not hold up bytes that close no message.
module tcp_internet_checksum
    import tcpck_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [87:0] s_axis_tdata,  // data_byte, init_sum, src_addr, dst_addr
    input  wire logic        s_axis_tlast,  // last_byte
    input  wire logic [1:0]  s_axis_tuser,  // first_byte, sum_kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // checksum, byte_count
);

    logic        item_valid;
    logic        item_ready;
    tcpck_item_t item;

    // Register the request and its start sum
    tcpck_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item)
    );

    // Accumulate and produce results
    tcpck_accum u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire
